### design/nsd_pkg.sv
// Package for the OFDM null symbol detector.
// Holds widths, reset values, mode and register codes and the shared structs.
// No dependencies.
package nsd_pkg;

    localparam int WINDOW_LEN  = 50;
    localparam int ALPHA_SHIFT = 17;
    localparam int MAG_BITS    = 16;

    localparam int FRAME_W  = 18;
    localparam int NULL_W   = 16;
    localparam int CNT_W    = FRAME_W;
    localparam int PTR_W    = $clog2(WINDOW_LEN);
    localparam int SUM_W    = MAG_BITS + PTR_W;
    localparam int LVL_W    = MAG_BITS + ALPHA_SHIFT;
    localparam int DIP_W    = SUM_W + ALPHA_SHIFT + 1;
    localparam int END_W    = DIP_W + 1;
    localparam int MODE_W   = 3;

    localparam int IN_FIELDS_W  = MAG_BITS + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = MODE_W + 2 + MAG_BITS;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FRAME_W;

    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(196608);
    localparam logic [NULL_W-1:0]  NULL_RESET  = NULL_W'(2656);

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT     = 3'd0,
        MODE_WARMUP   = 3'd1,
        MODE_FILL     = 3'd2,
        MODE_DIP      = 3'd3,
        MODE_NULL_END = 3'd4,
        MODE_LOCKED   = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_SAMPLES = 1'b0,
        CFG_NULL_SAMPLES  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_mode               mode;
        logic                sync_found;
        logic                timed_out;
        logic [MAG_BITS-1:0] level_out;
    } t_result;

    typedef struct packed {
        logic                wr_en;
        logic [PTR_W-1:0]    wr_addr;
        logic [MAG_BITS-1:0] wr_data;
        logic [PTR_W-1:0]    rd_addr;
    } t_win_req;

endpackage

### design/nsd_window.sv
// Sample store for the moving-sum window: one write and one registered read per cycle.
// Depends on nsd_pkg.
module nsd_window (
    input  logic                         i_clk,
    input  nsd_pkg::t_win_req            i_req,
    output logic [nsd_pkg::MAG_BITS-1:0] o_rd_data
);
    import nsd_pkg::*;

    logic [MAG_BITS-1:0] r_mem [WINDOW_LEN];
    logic [MAG_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/nsd_core.sv
// Detector state: mode sequencer, long-term level, moving window sum and timeouts.
// Depends on nsd_pkg and nsd_window.
module nsd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [nsd_pkg::MAG_BITS-1:0] i_envelope,
    input  logic                        i_restart,
    input  logic [nsd_pkg::FRAME_W-1:0] i_frame_samples,
    input  logic [nsd_pkg::NULL_W-1:0]  i_null_samples,
    output nsd_pkg::t_result            o_result
);
    import nsd_pkg::*;

    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [LVL_W-1:0]  r_lvl,  n_lvl;
    logic [SUM_W-1:0]  r_sum,  n_sum;
    logic [PTR_W-1:0]  r_ptr,  n_ptr;

    t_win_req            win_req;
    logic [MAG_BITS-1:0] win_rd;

    nsd_window u_window (
        .i_clk     (i_clk),
        .i_req     (win_req),
        .o_rd_data (win_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WAIT;
            r_cnt  <= '0;
            r_lvl  <= '0;
            r_sum  <= '0;
            r_ptr  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_lvl  <= n_lvl;
            r_sum  <= n_sum;
            r_ptr  <= n_ptr;
        end
    end

    always_comb begin
        t_mode            ph;
        logic [CNT_W-1:0] cnt;
        logic [LVL_W-1:0] lvl;
        logic [SUM_W-1:0] sum;
        logic [PTR_W-1:0] ptr;
        logic [CNT_W-1:0] half;
        logic [CNT_W-1:0] null_lim;
        logic [CNT_W-1:0] cnt_inc;
        logic [PTR_W-1:0] ptr_inc;
        logic [LVL_W-1:0] lvl_upd;
        logic [SUM_W-1:0] sum_add;
        logic             sliding;
        logic             dip_met;
        logic             end_met;
        logic             sync;
        logic             tout;
        logic             wr;

        ph  = r_mode;
        cnt = r_cnt;
        lvl = r_lvl;
        sum = r_sum;
        ptr = r_ptr;

        half     = CNT_W'(i_frame_samples >> 1);
        null_lim = CNT_W'(i_null_samples) + CNT_W'(WINDOW_LEN);

        // restart, then pass through any wait that is already over
        if (i_restart) begin
            ph  = MODE_WARMUP;
            cnt = '0;
            lvl = '0;
        end
        if (ph == MODE_WAIT && cnt >= half) begin
            ph  = MODE_WARMUP;
            cnt = '0;
            lvl = '0;
        end
        if (ph == MODE_WARMUP && cnt >= CNT_W'(i_frame_samples)) begin
            ph  = MODE_FILL;
            cnt = '0;
            sum = '0;
            ptr = '0;
        end

        lvl_upd = lvl + LVL_W'(i_envelope) - (lvl >> ALPHA_SHIFT);
        sliding = (ph == MODE_DIP) || (ph == MODE_NULL_END);
        sum_add = sum + SUM_W'(i_envelope) - (sliding ? SUM_W'(win_rd) : SUM_W'(0));
        dip_met = {sum_add, (ALPHA_SHIFT + 1)'(0)}
                  <= DIP_W'(lvl_upd) * DIP_W'(WINDOW_LEN);
        end_met = {sum_add, (ALPHA_SHIFT + 2)'(0)}
                  >= END_W'(lvl_upd) * END_W'(3 * WINDOW_LEN);
        cnt_inc = cnt + CNT_W'(1);
        ptr_inc = (ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr + PTR_W'(1);

        n_mode = ph;
        n_cnt  = cnt;
        n_lvl  = lvl_upd;
        n_sum  = sum;
        n_ptr  = ptr;
        sync   = 1'b0;
        tout   = 1'b0;
        wr     = 1'b0;

        unique case (ph)
            MODE_WAIT: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= half) begin
                    n_mode = MODE_WARMUP;
                    n_cnt  = '0;
                    n_lvl  = '0;
                    if (i_frame_samples == '0) begin
                        n_mode = MODE_FILL;
                        n_sum  = '0;
                        n_ptr  = '0;
                    end
                end
            end
            MODE_WARMUP: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= CNT_W'(i_frame_samples)) begin
                    n_mode = MODE_FILL;
                    n_cnt  = '0;
                    n_sum  = '0;
                    n_ptr  = '0;
                end
            end
            MODE_FILL: begin
                wr    = 1'b1;
                n_sum = sum_add;
                n_ptr = ptr_inc;
                n_cnt = cnt_inc;
                if (cnt_inc >= CNT_W'(WINDOW_LEN)) begin
                    n_ptr  = '0;
                    n_mode = MODE_DIP;
                    n_cnt  = '0;
                    if (dip_met) begin
                        n_mode = MODE_NULL_END;
                        if (end_met) begin
                            n_mode = MODE_LOCKED;
                            sync   = 1'b1;
                        end
                    end
                end
            end
            MODE_DIP, MODE_NULL_END: begin
                wr    = 1'b1;
                n_sum = sum_add;
                n_ptr = ptr_inc;
                if ((ph == MODE_DIP && cnt >= CNT_W'(i_frame_samples)) ||
                    (ph == MODE_NULL_END && cnt >= null_lim)) begin
                    tout   = 1'b1;
                    n_mode = MODE_WARMUP;
                    n_cnt  = '0;
                    n_lvl  = '0;
                    if (i_frame_samples == '0) begin
                        n_mode = MODE_FILL;
                        n_sum  = '0;
                        n_ptr  = '0;
                    end
                end else begin
                    n_cnt = cnt_inc;
                    if (ph == MODE_DIP) begin
                        if (dip_met) begin
                            n_mode = MODE_NULL_END;
                            n_cnt  = '0;
                            if (end_met) begin
                                n_mode = MODE_LOCKED;
                                sync   = 1'b1;
                            end
                        end
                    end else if (end_met) begin
                        n_mode = MODE_LOCKED;
                        n_cnt  = '0;
                        sync   = 1'b1;
                    end
                end
            end
            default: begin
                n_mode = MODE_LOCKED;
            end
        endcase

        win_req.wr_en   = i_step && wr;
        win_req.wr_addr = ptr;
        win_req.wr_data = i_envelope;
        win_req.rd_addr = i_step ? n_ptr : r_ptr;

        o_result.mode       = n_mode;
        o_result.sync_found = sync;
        o_result.timed_out  = tout;
        o_result.level_out  = n_lvl[LVL_W-1:ALPHA_SHIFT];
    end

endmodule

### design/ofdm_null_symbol_detector.sv
// OFDM null symbol detector: coarse frame sync on the envelope of a baseband stream.
// Top level with stream handshakes, configuration registers and output register.
// Depends on nsd_pkg and nsd_core.
//
// Input stream: one request per sample, tdata carries the envelope and a restart flag.
// Output stream: one result per sample, tdata carries the mode after the sample,
// the sync pulse, the timeout pulse and the integer part of the long-term level.
// Configuration: frame length (index 0) and null length (index 1), written through
// the cfg channel while the stream is idle; o_cfg_ready is always high.
// A sample accepted into the input register is processed into the output
// register, which offers its result, once that register is empty or being read.
// Throughput: one sample per cycle while the receiver does not stall; the
// window store has one write and one registered read port, and its read
// address runs one sample ahead.
// Reset: the detector returns to the initial half-frame wait with the level,
// window sum and counters cleared and the registers at their defaults; no
// clearing pass is needed, the window is filled before it is read.
// A stalled receiver holds the result in the output register; one more
// sample waits in the input register, then s_axis_tready drops.
module ofdm_null_symbol_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] envelope, [16] restart, rest zero
    input  logic [nsd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] mode, [3] sync_found, [4] timed_out, [20:5] level_out, rest zero
    output logic [nsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nsd_pkg::*;

    logic                r_in_vld;
    logic [MAG_BITS-1:0] r_in_env;
    logic                r_in_rst;
    logic                r_out_vld;
    t_result             r_out;
    logic [FRAME_W-1:0]  r_frame_samples;
    logic [NULL_W-1:0]   r_null_samples;
    logic                step;
    t_result             result;

    assign step          = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || step;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_samples <= FRAME_RESET;
            r_null_samples  <= NULL_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_SAMPLES: r_frame_samples <= i_cfg_data;
                CFG_NULL_SAMPLES:  r_null_samples  <= i_cfg_data[NULL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_env <= s_axis_tdata[MAG_BITS-1:0];
            r_in_rst <= s_axis_tdata[MAG_BITS];
        end
    end

    nsd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_envelope      (r_in_env),
        .i_restart       (r_in_rst),
        .i_frame_samples (r_frame_samples),
        .i_null_samples  (r_null_samples),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), r_out.level_out,
                            r_out.timed_out, r_out.sync_found, MODE_W'(r_out.mode)};

endmodule

### design/nsd_checker.sv
// Port-level checks for the null symbol detector, bound to the top level.
// Depends on nsd_pkg and ofdm_null_symbol_detector.
module nsd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [nsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import nsd_pkg::*;

    // a result never both locks and times out
    a_sync_tout_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[MODE_W] && m_axis_tdata[MODE_W+1]))
        else $error("sync and timeout on the same result");

    a_sync_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[MODE_W]) |->
            (m_axis_tdata[MODE_W-1:0] == MODE_W'(MODE_LOCKED)))
        else $error("sync without locked mode");

    // a timeout restarts warm-up, or passes straight to fill
    a_tout_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[MODE_W+1]) |->
            (m_axis_tdata[MODE_W-1:0] == MODE_W'(MODE_WARMUP) ||
             m_axis_tdata[MODE_W-1:0] == MODE_W'(MODE_FILL)))
        else $error("timeout left the wrong mode");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind ofdm_null_symbol_detector nsd_checker u_nsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### dv/null_sync_scoreboard_pkg.sv
// Scoreboard for the OFDM null symbol detector testbench.
// Tracks the detector modes, long-term level and moving window, and checks results.
// Depends on nsd_pkg.
package null_sync_scoreboard_pkg;

    import nsd_pkg::*;

    class null_sync_scoreboard;

        logic [FRAME_W-1:0]  frame_len;
        logic [NULL_W-1:0]   null_len;
        t_mode               mode_now;
        logic [CNT_W-1:0]    step_cnt;
        logic [LVL_W-1:0]    level_acc;
        logic [MAG_BITS-1:0] window [WINDOW_LEN];
        logic [PTR_W-1:0]    win_ptr;
        logic [SUM_W-1:0]    win_sum;
        t_result             expected_status [$];
        int unsigned         mismatches;
        int unsigned         samples;
        int unsigned         results_seen;
        int unsigned         syncs;
        int unsigned         timeouts;

        function new();
            frame_len    = FRAME_RESET;
            null_len     = NULL_RESET;
            mode_now     = MODE_WAIT;
            step_cnt     = '0;
            level_acc    = '0;
            win_ptr      = '0;
            win_sum      = '0;
            foreach (window[i]) window[i] = '0;
            mismatches   = 0;
            samples      = 0;
            results_seen = 0;
            syncs        = 0;
            timeouts     = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_FRAME_SAMPLES) begin
                frame_len = value;
            end else begin
                null_len = value[NULL_W-1:0];
            end
        endfunction

        // sum*2 <= WINDOW_LEN*level, in level fraction bits
        function bit dip_reached();
            logic [63:0] scaled_sum;
            logic [63:0] scaled_level;
            scaled_sum   = 64'(win_sum) << (ALPHA_SHIFT + 1);
            scaled_level = 64'(WINDOW_LEN) * 64'(level_acc);
            return scaled_sum <= scaled_level;
        endfunction

        // sum*4 >= 3*WINDOW_LEN*level
        function bit null_end_reached();
            logic [63:0] scaled_sum;
            logic [63:0] scaled_level;
            scaled_sum   = 64'(win_sum) << (ALPHA_SHIFT + 2);
            scaled_level = 64'(3 * WINDOW_LEN) * 64'(level_acc);
            return scaled_sum >= scaled_level;
        endfunction

        function void restart_warmup();
            mode_now  = MODE_WARMUP;
            step_cnt  = '0;
            level_acc = '0;
        endfunction

        // waits of zero length, or already overrun, pass without a sample
        function void skip_spent_waits();
            if (mode_now == MODE_WAIT && step_cnt >= (frame_len >> 1)) restart_warmup();
            if (mode_now == MODE_WARMUP && step_cnt >= frame_len) begin
                mode_now = MODE_FILL;
                step_cnt = '0;
                win_sum  = '0;
                win_ptr  = '0;
            end
        endfunction

        function bit open_dip_search();
            mode_now = MODE_DIP;
            step_cnt = '0;
            if (!dip_reached()) return 1'b0;
            mode_now = MODE_NULL_END;
            if (!null_end_reached()) return 1'b0;
            mode_now = MODE_LOCKED;
            return 1'b1;
        endfunction

        function void slide_window(logic [MAG_BITS-1:0] mag);
            int unsigned slot;
            slot = win_ptr % WINDOW_LEN;
            win_sum = win_sum + mag - window[slot];
            window[slot] = mag;
            win_ptr = PTR_W'((slot + 1) % WINDOW_LEN);
        endfunction

        function void note_sample(logic [MAG_BITS-1:0] mag, logic restart);
            logic sync_hit;
            logic search_expired;
            sync_hit       = 1'b0;
            search_expired = 1'b0;
            if (restart) restart_warmup();
            skip_spent_waits();
            level_acc = level_acc + mag - (level_acc >> ALPHA_SHIFT);
            case (mode_now)
                MODE_WAIT, MODE_WARMUP: begin
                    step_cnt++;
                    skip_spent_waits();
                end
                MODE_FILL: begin
                    window[win_ptr % WINDOW_LEN] = mag;
                    win_sum  = win_sum + mag;
                    win_ptr  = PTR_W'((win_ptr % WINDOW_LEN) + 1);
                    step_cnt++;
                    if (step_cnt >= WINDOW_LEN) begin
                        win_ptr  = '0;
                        sync_hit = open_dip_search();
                    end
                end
                MODE_DIP: begin
                    slide_window(mag);
                    if (step_cnt >= frame_len) begin
                        search_expired = 1'b1;
                        restart_warmup();
                        skip_spent_waits();
                    end else begin
                        step_cnt++;
                        if (dip_reached()) begin
                            mode_now = MODE_NULL_END;
                            step_cnt = '0;
                            if (null_end_reached()) begin
                                mode_now = MODE_LOCKED;
                                sync_hit = 1'b1;
                            end
                        end
                    end
                end
                MODE_NULL_END: begin
                    slide_window(mag);
                    if (step_cnt >= null_len + WINDOW_LEN) begin
                        search_expired = 1'b1;
                        restart_warmup();
                        skip_spent_waits();
                    end else begin
                        step_cnt++;
                        if (null_end_reached()) begin
                            mode_now = MODE_LOCKED;
                            step_cnt = '0;
                            sync_hit = 1'b1;
                        end
                    end
                end
                default: mode_now = MODE_LOCKED;
            endcase
            expected_status.push_back('{mode:       mode_now,
                                        sync_found: sync_hit,
                                        timed_out:  search_expired,
                                        level_out:  level_acc[ALPHA_SHIFT +: MAG_BITS]});
            samples++;
            syncs    += sync_hit;
            timeouts += search_expired;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            t_result             want;
            t_mode               got_mode;
            logic                got_sync;
            logic                got_tout;
            logic [MAG_BITS-1:0] got_level;
            got_mode  = t_mode'(word[MODE_W-1:0]);
            got_sync  = word[MODE_W];
            got_tout  = word[MODE_W+1];
            got_level = word[MODE_W+2 +: MAG_BITS];
            results_seen++;
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d unexpected: mode %0d sync %0b timeout %0b level %0d",
                             results_seen, got_mode, got_sync, got_tout, got_level);
                return;
            end
            want = expected_status.pop_front();
            if (got_mode !== want.mode || got_sync !== want.sync_found ||
                got_tout !== want.timed_out || got_level !== want.level_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: exp mode %0d sync %0b timeout %0b level %0d, got %0d %0b %0b %0d",
                             results_seen, want.mode, want.sync_found, want.timed_out,
                             want.level_out, got_mode, got_sync, got_tout, got_level);
            end
        endfunction

    endclass

endpackage

### dv/tb_ofdm_null_symbol_detector.sv
// Testbench top for the OFDM null symbol detector.
// Drives envelope samples, restarts and register writes under varied idling.
// Depends on nsd_pkg, null_sync_scoreboard_pkg and ofdm_null_symbol_detector.
module tb_ofdm_null_symbol_detector;

    import nsd_pkg::*;
    import null_sync_scoreboard_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 150;

    typedef enum {SEG_SIGNAL, SEG_NULL, SEG_NOISE, SEG_ZERO} t_segment;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    null_sync_scoreboard sb;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int reg_writes      = 0;

    t_segment seg_kind    = SEG_SIGNAL;
    int       seg_left    = 0;
    int       seg_floor   = 0;
    int       seg_ceiling = 0;
    int       lock_wait   = -1;

    ofdm_null_symbol_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
            $display("ofdm_null_symbol_detector test failed");
            $finish;
        end
    end

    task automatic send_sample(logic [MAG_BITS-1:0] env, logic rst_flag);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_TDATA_W'({rst_flag, env});
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(env, rst_flag);
    endtask

    task automatic program_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, value);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic settle_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly signal / null stretches so that dips and null ends occur
    task automatic next_sample(output logic [MAG_BITS-1:0] env, output logic rst_flag);
        int r;
        if (seg_left == 0) begin
            r = $urandom_range(99);
            if (r < 40) begin
                seg_kind  = SEG_SIGNAL;
                seg_left  = $urandom_range(120, 10);
                seg_floor = $urandom_range(60000);
            end else if (r < 75) begin
                seg_kind    = SEG_NULL;
                seg_left    = $urandom_range(110, 30);
                seg_ceiling = $urandom_range(40);
            end else if (r < 90) begin
                seg_kind = SEG_NOISE;
                seg_left = $urandom_range(30, 1);
            end else begin
                seg_kind = SEG_ZERO;
                seg_left = $urandom_range(80, 1);
            end
        end
        seg_left--;
        case (seg_kind)
            SEG_SIGNAL: env = MAG_BITS'($urandom_range(65535, seg_floor));
            SEG_NULL:   env = MAG_BITS'($urandom_range(seg_ceiling, 0));
            SEG_NOISE:  env = MAG_BITS'($urandom());
            default:    env = '0;
        endcase
        rst_flag = 1'b0;
        if (sb.mode_now == MODE_LOCKED) begin
            if (lock_wait < 0) lock_wait = $urandom_range(12);
            if (lock_wait == 0) begin
                rst_flag  = 1'b1;
                lock_wait = -1;
            end else begin
                lock_wait--;
            end
        end else begin
            lock_wait = -1;
            rst_flag  = ($urandom_range(249) == 0);
        end
    endtask

    task automatic run_phase(int n_items, int hold_at, int pause_at);
        logic [MAG_BITS-1:0] env;
        logic                rst_flag;
        for (int i = 0; i < n_items; i++) begin
            next_sample(env, rst_flag);
            send_sample(env, rst_flag);
            if (i == hold_at) hold_left = HOLD_CYCLES;
            if (i == pause_at) settle_idle();
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults, restart in the first wait
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0001, 1'b0);
        settle_idle();
        program_register(CFG_FRAME_SAMPLES, 18'h3FFFF);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        settle_idle();
        // frame and null of one sample: warm-up already overrun
        program_register(CFG_FRAME_SAMPLES, 18'd1);
        program_register(CFG_NULL_SAMPLES, 18'd1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h7FFF, 1'b0);

        run_phase(310, 100, -1);

        settle_idle();
        program_register(CFG_FRAME_SAMPLES, 18'd150);
        program_register(CFG_NULL_SAMPLES, 18'd100);
        sender_idle_pct = 56;
        run_phase(310, -1, 150);

        settle_idle();
        program_register(CFG_FRAME_SAMPLES, 18'd80);
        program_register(CFG_NULL_SAMPLES, 18'd65535);
        sender_idle_pct = 0;
        stall_pct       = 56;
        run_phase(310, -1, -1);

        settle_idle();
        program_register(CFG_FRAME_SAMPLES, CFG_DATA_W'($urandom_range(300, 40)));
        program_register(CFG_NULL_SAMPLES, CFG_DATA_W'($urandom_range(200, 1)));
        sender_idle_pct = 28;
        stall_pct       = 28;
        run_phase(310, -1, -1);

        settle_idle();
        repeat (10) @(posedge i_clk);

        $display("Ran %0d samples through %0d register writes: %0d sync pulses, %0d timeouts.",
                 sb.samples, reg_writes, sb.syncs, sb.timeouts);
        $display("Idle mixes: none, sender, receiver, both; one long receiver hold-off.");
        if (sb.mismatches == 0 && sb.expected_status.size() == 0) begin
            $display("ofdm_null_symbol_detector test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_status.size());
            $display("ofdm_null_symbol_detector test failed");
        end
        $finish;
    end

endmodule

### ofdm_null_symbol_detector.f
design/nsd_pkg.sv
design/nsd_window.sv
design/nsd_core.sv
design/ofdm_null_symbol_detector.sv
design/nsd_checker.sv
dv/null_sync_scoreboard_pkg.sv
dv/tb_ofdm_null_symbol_detector.sv
